[hdl/rot_pkg.sv]
// ----------------------------------------------------------------------------
// rot_pkg
// Types and constants shared by the range OR update and AND query block.
// ----------------------------------------------------------------------------
package rot_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 64;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_OR    = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] range_left;
    logic [IDX_W-1:0] range_right;
    logic [VAL_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] and_result;
    logic             range_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic bad_query;
    logic clr_step;
    logic mem_we;
    logic wsel_load;
    logic step;
    logic acc_en;
    logic out_load;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  at_right;
    logic  new_bad;
    logic  new_load_ok;
    kind_t new_kind;
    kind_t cur_kind;
    logic  out_busy;
  } sts_t;

endpackage

[hdl/rot_datapath.sv]
// ----------------------------------------------------------------------------
// rot_datapath
// Element memory, index counter, AND accumulator and result register.
// ----------------------------------------------------------------------------
module rot_datapath import rot_pkg::*; #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;

  logic [VAL_W-1:0] mem [LEAF_COUNT];
  in_item_t         item_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             err_r, err_nxt;
  logic [VAL_W-1:0] rdata_r;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;

  assign waddr = cmd.clr_step ? clr_r : AW'(cnt_r);
  assign wdata = cmd.clr_step  ? '0 :
                 cmd.wsel_load ? item_r.operand_value :
                                 (rdata_r | item_r.operand_value);

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[AW'(cnt_r)];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    err_nxt = err_r;
    clr_nxt = clr_r;
    if (cmd.start) begin
      cnt_nxt = in_data.range_left;
      acc_nxt = '1;
      err_nxt = cmd.bad_query;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.acc_en) begin
      acc_nxt = acc_r & rdata_r;
    end
    if (cmd.clr_step) begin
      clr_nxt = clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= in_data;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    err_r <= err_nxt;
    if (cmd.out_load) begin
      out_data_r.and_result  <= acc_r;
      out_data_r.range_error <= err_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.clr_last    = (clr_r == AW'(LEAF_COUNT - 1));
  assign sts.at_right    = (cnt_r == item_r.range_right);
  assign sts.new_bad     = (in_data.range_left > in_data.range_right) ||
                           (32'(in_data.range_right) >= 32'(LEAF_COUNT));
  assign sts.new_load_ok = (32'(in_data.range_left) < 32'(LEAF_COUNT));
  assign sts.new_kind    = kind_t'(in_data.kind);
  assign sts.cur_kind    = kind_t'(item_r.kind);
  assign sts.out_busy    = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/rot_ctrl.sv]
// ----------------------------------------------------------------------------
// rot_ctrl
// Sequencer for memory clearing, element loads and range sweeps.
// ----------------------------------------------------------------------------
module rot_ctrl import rot_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.mem_we   = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.bad_query = sts.new_bad;
        if (in_valid) begin
          cmd.start = 1'b1;
          case (sts.new_kind)
            KIND_LOAD:  state_nxt = sts.new_load_ok ? ST_LOAD : ST_IDLE;
            KIND_OR:    state_nxt = sts.new_bad ? ST_IDLE : ST_READ;
            KIND_QUERY: state_nxt = sts.new_bad ? ST_DONE : ST_READ;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (sts.cur_kind == KIND_OR) begin
          cmd.mem_we = 1'b1;
        end else begin
          cmd.acc_en = 1'b1;
        end
        if (sts.at_right) begin
          state_nxt = (sts.cur_kind == KIND_OR) ? ST_IDLE : ST_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_LOAD: begin
        cmd.mem_we    = 1'b1;
        cmd.wsel_load = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/range_or_update_and_query_tree.sv]
// ----------------------------------------------------------------------------
// range_or_update_and_query_tree
// Array of 64-bit words with point load, range OR update and range AND query.
//
// The input channel carries one item per handshake: a load of one element,
// an OR of a mask into an inclusive index range, or an AND query over a
// range. Only a query produces an item on the output channel.
// After reset the element memory is cleared, one entry per cycle; in_stall
// stays high during that pass. A load writes its one element. An OR update
// or a query visits each element of the range in turn: ST_READ registers
// the element read from memory, then ST_UPD writes it back ORed with the
// mask or ANDs it into the accumulator. A bad range ends without a sweep;
// a bad query returns all ones with range_error set.
// Query results sit in an output register, so the next item is accepted
// while a result waits. If out_stall holds a result there when the next
// query finishes, that query waits and in_stall stays high.
// ----------------------------------------------------------------------------
module range_or_update_and_query_tree import rot_pkg::*; #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t cmd;
  sts_t sts;

  rot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  rot_datapath #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !cmd.in_ready;

  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && sts.new_kind == KIND_QUERY) |=> in_stall)
    else $error("item accepted while a query is still in progress");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> in_stall)
    else $error("item accepted during memory clearing");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  a_single_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_we && cmd.wsel_load) |-> !cmd.clr_step && !cmd.acc_en)
    else $error("conflicting memory write commands");

endmodule
